FILE: hdl/apq_pkg.sv
// Shared types and constants for the array priority queue.
// No dependencies.
`timescale 1ns / 1ps
package apq_pkg;

  localparam int CAP_WIDTH = 8;
  localparam int OCC_WIDTH = 8;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 8'd128;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_ctl_t;

endpackage

FILE: hdl/apq_if.sv
// Request and response channel interfaces of the array priority queue.
// Depends on apq_pkg.
`timescale 1ns / 1ps
interface apq_req_if #(
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 8
);
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [PAYLOAD_WIDTH-1:0]  payload;
  logic [PRIORITY_WIDTH-1:0] priority_req;

  modport source (output valid, output operation, output payload, output priority_req,
                  input ready);
  modport sink (input valid, input operation, input payload, input priority_req,
                output ready);
endinterface

interface apq_rsp_if #(
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 8
);
  logic                          valid;
  logic                          ready;
  logic [PAYLOAD_WIDTH-1:0]      out_payload;
  logic [PRIORITY_WIDTH-1:0]     out_priority;
  apq_pkg::status_t              status;
  logic [apq_pkg::OCC_WIDTH-1:0] occupancy;

  modport source (output valid, output out_payload, output out_priority, output status,
                  output occupancy, input ready);
  modport sink (input valid, input out_payload, input out_priority, input status,
                input occupancy, output ready);
endinterface

FILE: hdl/apq_front.sv
// Front end: accepts requests, decodes the operation and buffers them
// in a two-entry command queue. Depends on apq_pkg and apq_req_if.
`timescale 1ns / 1ps
module apq_front #(
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  apq_req_if.sink                   req,
  output apq_pkg::cmd_ctl_t         cmd,
  output logic [PAYLOAD_WIDTH-1:0]  cmd_payload,
  output logic [PRIORITY_WIDTH-1:0] cmd_priority,
  input  logic                      pop
);
  import apq_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  op_t                       q_op  [QDEPTH];
  logic [PAYLOAD_WIDTH-1:0]  q_pay [QDEPTH];
  logic [PRIORITY_WIDTH-1:0] q_pri [QDEPTH];
  logic [PTR_W-1:0]          wr_ptr;
  logic [PTR_W-1:0]          rd_ptr;
  logic [FILL_W-1:0]         fill;
  logic                      push;
  logic                      do_pop;

  assign req.ready = (fill != FILL_W'(QDEPTH));
  assign push      = req.valid && req.ready;
  assign do_pop    = pop && (fill != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]  <= op_t'(req.operation);
      q_pay[wr_ptr] <= req.payload;
      q_pri[wr_ptr] <= req.priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign cmd.valid    = (fill != '0);
  assign cmd.op       = q_op[rd_ptr];
  assign cmd_payload  = q_pay[rd_ptr];
  assign cmd_priority = q_pri[rd_ptr];

endmodule

FILE: hdl/apq_back.sv
// Back end: sorted shift chain of entries, occupancy and capacity
// registers, and the response register. Depends on apq_pkg and apq_rsp_if.
`timescale 1ns / 1ps
module apq_back #(
  parameter int DEPTH          = 128,
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [apq_pkg::CAP_WIDTH-1:0]   cfg_data,
  input  apq_pkg::cmd_ctl_t               cmd,
  input  logic [PAYLOAD_WIDTH-1:0]        cmd_payload,
  input  logic [PRIORITY_WIDTH-1:0]       cmd_priority,
  output logic                            pop,
  apq_rsp_if.source                       rsp
);
  import apq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > CAP_WIDTH) ? CNT_W : CAP_WIDTH;

  // chain cells, kept sorted by priority then arrival; head is the minimum
  logic [PAYLOAD_WIDTH-1:0]  pay [DEPTH];
  logic [PRIORITY_WIDTH-1:0] pri [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]  ins_pay [DEPTH];
  logic [PRIORITY_WIDTH-1:0] ins_pri [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]  dn_pay [DEPTH];
  logic [PRIORITY_WIDTH-1:0] dn_pri [DEPTH];
  logic [DEPTH-1:0]          behind;
  logic [DEPTH-1:0]          take_new;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CAP_WIDTH-1:0] capacity;
  logic [LIM_W-1:0]     limit;
  logic                 exec;
  logic                 enq_ok;
  logic                 deq_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  assign limit  = (LIM_W'(capacity) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(capacity);
  assign exec   = cmd.valid && (!rsp.valid || rsp.ready);
  assign pop    = exec;
  assign enq_ok = exec && (cmd.op == OP_ENQ) && (LIM_W'(count) < limit);
  assign deq_ok = exec && (cmd.op == OP_DEQ) && (count != '0);

  // cells at or past the occupancy, or holding a larger priority, move back
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      behind[i] = (CNT_W'(i) >= count) || (pri[i] > cmd_priority);
    end
    take_new[0] = behind[0];
    for (int i = 1; i < DEPTH; i++) begin
      take_new[i] = behind[i] && !behind[i-1];
    end
    ins_pay[0] = cmd_payload;
    ins_pri[0] = cmd_priority;
    for (int i = 1; i < DEPTH; i++) begin
      ins_pay[i] = take_new[i] ? cmd_payload : pay[i-1];
      ins_pri[i] = take_new[i] ? cmd_priority : pri[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      dn_pay[i] = pay[i+1];
      dn_pri[i] = pri[i+1];
    end
    dn_pay[DEPTH-1] = pay[DEPTH-1];
    dn_pri[DEPTH-1] = pri[DEPTH-1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (enq_ok && behind[i]) begin
        pay[i] <= ins_pay[i];
        pri[i] <= ins_pri[i];
      end else if (deq_ok) begin
        pay[i] <= dn_pay[i];
        pri[i] <= dn_pri[i];
      end
    end
  end

  always_comb begin
    priority if (enq_ok) begin
      count_next = count + 1'b1;
    end else if (deq_ok) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (exec) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp.out_payload  <= deq_ok ? pay[0] : '0;
      rsp.out_priority <= deq_ok ? pri[0] : '0;
      rsp.occupancy    <= OCC_WIDTH'(count_next);
      unique case (cmd.op)
        OP_ENQ: rsp.status <= enq_ok ? ST_DONE : ST_FULL;
        OP_DEQ: rsp.status <= deq_ok ? ST_DONE : ST_EMPTY;
        default: rsp.status <= ST_DONE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (pri[0] <= pri[1]))
    else $error("chain head out of order");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    enq_ok |=> (count == $past(count) + 1'b1))
    else $error("enqueue did not advance occupancy");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0 && rsp.out_payload == '0))
    else $error("empty response with stale fields");
`endif

endmodule

FILE: hdl/array_priority_queue.sv
// Array priority queue: enqueue or dequeue-minimum per request, one response each.
// A transferred request is written to the command queue, then executed on the chain into the response register.
// Throughput: one request per cycle while responses are taken (rsp.ready); all chain cells update together.
// Reset (rst, synchronous): queue empty, capacity 128, no response pending.
// Stored entries are not cleared; the occupancy count masks them.
`timescale 1ns / 1ps
module array_priority_queue #(
  parameter int DEPTH          = 128,
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [apq_pkg::CAP_WIDTH-1:0] cfg_data,
  apq_req_if.sink                       req,
  apq_rsp_if.source                     rsp
);
  import apq_pkg::*;

  cmd_ctl_t                  cmd;
  logic [PAYLOAD_WIDTH-1:0]  cmd_payload;
  logic [PRIORITY_WIDTH-1:0] cmd_priority;
  logic                      pop;

  apq_front #(
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cmd         (cmd),
    .cmd_payload (cmd_payload),
    .cmd_priority(cmd_priority),
    .pop         (pop)
  );

  apq_back #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .cmd_payload (cmd_payload),
    .cmd_priority(cmd_priority),
    .pop         (pop),
    .rsp         (rsp)
  );

endmodule

FILE: tb/apq_checker.sv
// Response checker for the array priority queue: keeps its own copy of the queue,
// predicts the response to every request transfer and compares it field by field.
// Depends on apq_pkg and the channel interfaces in apq_if.sv.
`timescale 1ns / 1ps
module apq_checker #(
  parameter int DEPTH          = 128,
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [apq_pkg::CAP_WIDTH-1:0] cfg_data,
  apq_req_if                            req,
  apq_rsp_if                            rsp,
  output int                            mismatches,
  output int                            outstanding
);
  import apq_pkg::*;

  typedef struct {
    logic [PAYLOAD_WIDTH-1:0]  payload;
    logic [PRIORITY_WIDTH-1:0] prio;
    status_t                   status;
    logic [OCC_WIDTH-1:0]      occ;
  } queue_result_t;

  // entries in insertion order; only slots below entry_total are ever read
  logic [PAYLOAD_WIDTH-1:0]  payload_slots [DEPTH];
  logic [PRIORITY_WIDTH-1:0] prio_slots    [DEPTH];
  int unsigned               entry_total;
  logic [CAP_WIDTH-1:0]      capacity;
  queue_result_t             pending_responses [$];
  int                        fail_count = 0;

  function automatic queue_result_t serve_op(op_t op, logic [PAYLOAD_WIDTH-1:0] pay,
                                             logic [PRIORITY_WIDTH-1:0] pri);
    queue_result_t r;
    int unsigned   limit;
    int unsigned   best;
    int unsigned   i;
    r.payload = '0;
    r.prio    = '0;
    r.status  = ST_DONE;
    limit = (capacity > DEPTH) ? DEPTH : capacity;
    if (op == OP_ENQ) begin
      if (entry_total < limit) begin
        payload_slots[entry_total] = pay;
        prio_slots[entry_total]    = pri;
        entry_total++;
      end else begin
        r.status = ST_FULL;
      end
    end else if (entry_total == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // strict less-than keeps the earliest of equal priorities
      best = 0;
      for (i = 1; i < entry_total; i++) begin
        if (prio_slots[i] < prio_slots[best]) best = i;
      end
      r.payload = payload_slots[best];
      r.prio    = prio_slots[best];
      // close the gap, keeping the order of the entries behind
      for (i = best; i + 1 < entry_total; i++) begin
        payload_slots[i] = payload_slots[i + 1];
        prio_slots[i]    = prio_slots[i + 1];
      end
      entry_total--;
    end
    r.occ = OCC_WIDTH'(entry_total);
    return r;
  endfunction

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      entry_total = 0;
      capacity    = CAP_RESET;
      pending_responses.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) capacity = cfg_data;
      // a response always belongs to an earlier request, so retire before adding
      if (rsp.valid && rsp.ready) begin
        if (pending_responses.size() == 0) begin
          $display({"%0t: response with none outstanding: payload 0x%0h priority 0x%0h",
                    " status %0d occupancy %0d"},
                   $time, rsp.out_payload, rsp.out_priority, rsp.status, rsp.occupancy);
          fail_count++;
        end else begin
          want = pending_responses.pop_front();
          compare_field("out_payload", 64'(want.payload), 64'(rsp.out_payload));
          compare_field("out_priority", 64'(want.prio), 64'(rsp.out_priority));
          compare_field("status", 64'(want.status), 64'(rsp.status));
          compare_field("occupancy", 64'(want.occ), 64'(rsp.occupancy));
        end
      end
      if (req.valid && req.ready) begin
        pending_responses.push_back(serve_op(op_t'(req.operation), req.payload,
                                             req.priority_req));
      end
      outstanding <= pending_responses.size();
    end
    mismatches <= fail_count;
  end

endmodule

FILE: tb/tb_top.sv
// Top of the array priority queue testbench: clock, reset, request and capacity stimulus,
// response back-pressure and the verdict. Depends on apq_pkg, apq_if.sv, apq_checker
// and the array_priority_queue RTL.
`timescale 1ns / 1ps
module tb_top;
  import apq_pkg::*;

  localparam int DEPTH      = 128;
  localparam int PW         = 32;
  localparam int QW         = 8;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CAP_WIDTH-1:0] cfg_data;
  int                   mismatches;
  int                   outstanding;
  int                   holds_asked   = 0;
  int                   holds_granted = 0;
  int                   idle_cycles   = 0;

  apq_req_if #(.PAYLOAD_WIDTH(PW), .PRIORITY_WIDTH(QW)) req ();
  apq_rsp_if #(.PAYLOAD_WIDTH(PW), .PRIORITY_WIDTH(QW)) rsp ();

  array_priority_queue #(
    .DEPTH(DEPTH), .PAYLOAD_WIDTH(PW), .PRIORITY_WIDTH(QW)
  ) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  apq_checker #(
    .DEPTH(DEPTH), .PAYLOAD_WIDTH(PW), .PRIORITY_WIDTH(QW)
  ) i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .req(req), .rsp(rsp),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hold valid and the fields until the transfer
  task automatic send_item(op_t op, logic [PW-1:0] pay, logic [QW-1:0] pri);
    req.valid        <= 1'b1;
    req.operation    <= op;
    req.payload      <= pay;
    req.priority_req <= pri;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_capacity(logic [CAP_WIDTH-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_phase(int n, int enq_pct, int pri_hi);
    int  sent;
    int  burst;
    int  gap;
    op_t op;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n; k++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_item(op, $urandom, QW'($urandom_range(0, pri_hi)));
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // keep offering back to back while the sink holds off, so the input stalls
  task automatic flood_during_hold(int n);
    holds_asked++;
    repeat (n) begin
      send_item(($urandom_range(0, 9) == 0) ? OP_DEQ : OP_ENQ, $urandom, QW'($urandom));
    end
  endtask

  // response back-pressure: long holds on request, else stretches of always ready, random and periodic stalls
  initial begin
    int mode;
    int stretch;
    int phase;
    rsp.ready = 1'b0;
    mode      = 0;
    stretch   = 0;
    phase     = 0;
    forever begin
      if (holds_granted != holds_asked) begin
        holds_granted++;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(10, 60);
        end
        stretch--;
        phase++;
        case (mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(0, 2) != 0);
          default: rsp.ready <= (phase % 5 < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[array_priority_queue] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    req.valid        = 1'b0;
    req.operation    = OP_ENQ;
    req.payload      = '0;
    req.priority_req = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: empty dequeue, then the all-zero entry in and out
    send_item(OP_DEQ, '1, '1);
    send_item(OP_ENQ, '0, '0);
    send_item(OP_DEQ, '0, '0);

    // fill to a small capacity with ties, refuse one, drain past empty
    set_capacity(8'd4);
    send_item(OP_ENQ, 32'hffff_ffff, 8'hff);
    send_item(OP_ENQ, 32'h1111_1111, 8'd7);
    send_item(OP_ENQ, 32'h2222_2222, 8'd7);
    send_item(OP_ENQ, 32'h3333_3333, 8'd3);
    send_item(OP_ENQ, 32'h4444_4444, 8'd0);
    repeat (5) send_item(OP_DEQ, '0, '0);

    // zero capacity refuses everything
    set_capacity(8'd0);
    send_item(OP_ENQ, 32'h8000_0001, 8'h80);
    send_item(OP_DEQ, '0, '0);

    // lower the capacity below the occupancy; entries stay
    set_capacity(8'd3);
    send_item(OP_ENQ, 32'ha5a5_a5a5, 8'd9);
    send_item(OP_ENQ, 32'h5a5a_5a5a, 8'd9);
    send_item(OP_ENQ, 32'h0f0f_0f0f, 8'd1);
    set_capacity(8'd1);
    send_item(OP_ENQ, 32'hdead_0001, 8'd0);
    send_item(OP_DEQ, '0, '0);
    send_item(OP_DEQ, '0, '0);
    send_item(OP_ENQ, 32'hdead_0002, 8'd0);
    send_item(OP_DEQ, '0, '0);
    send_item(OP_ENQ, 32'h1234_5678, 8'd128);
    send_item(OP_DEQ, '0, '0);

    // narrow priorities for plenty of ties
    set_capacity(8'd16);
    random_phase(120, 55, 7);

    // capacity above the depth: enqueue-heavy traffic, stall the output, then drain
    set_capacity(8'd255);
    random_phase(100, 85, 255);
    flood_during_hold(60);
    drain();
    random_phase(80, 80, 255);
    random_phase(100, 25, 255);

    set_capacity(8'd128);
    random_phase(60, 50, 255);

    set_capacity(8'd1);
    random_phase(60, 50, 255);

    set_capacity(CAP_WIDTH'($urandom_range(1, 128)));
    random_phase(60, 45, 31);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[array_priority_queue] OK");
    end else begin
      $display("[array_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/apq_pkg.sv
hdl/apq_if.sv
hdl/apq_front.sv
hdl/apq_back.sv
hdl/array_priority_queue.sv
tb/apq_checker.sv
tb/tb_top.sv
